// ----- hdl/htlp_pkg.sv -----
package htlp_pkg;

  // Fixed field widths
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 10;
  localparam int CFG_W   = 31;
  localparam int SIZE_W  = 11;
  localparam int DVD_W   = 64;
  localparam int CNT_W   = 6;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  // Register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_MULT = 2'd0;
  localparam logic [1:0] REG_MOD  = 2'd1;
  localparam logic [1:0] REG_SIZE = 2'd2;

  typedef logic [CFG_W-1:0] word_t;

endpackage

// ----- hdl/hash_table_linear_probe.sv -----
// Each accepted lookup or insert runs six reductions in one shared remainder unit
//   before its result, plus a slot read and check for each extra probed slot.
// Throughput: one item at a time; the next item is taken once the result is out.
// A clear advances the epoch, or resets it and sweeps the tags when the epoch wraps.
// Reset (rst_n low, synchronous) restores the registers and then sweeps the
//   tag memory with no item accepted.
module hash_table_linear_probe #(
  parameter int DEPTH      = 1024,
  parameter int EPOCH_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // key[31:0], write_value[63:32]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // read_value[31:0], slot[41:32], was_new[42],
                                  // full_error[43], zero[47:44]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import htlp_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int SW = AW + 1;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_MODW = 4'd2;
  localparam logic [3:0] S_MULT = 4'd3;
  localparam logic [3:0] S_ADDB = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_CHK  = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;

  localparam logic [1:0] P_MUL  = 2'd0;
  localparam logic [1:0] P_BYTE = 2'd1;
  localparam logic [1:0] P_SIZE = 2'd2;

  // configuration
  word_t             mult_r, modu_r;
  logic [SIZE_W-1:0] size_r;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r <= CFG_W'(131);
      modu_r <= CFG_W'(1000000007);
      size_r <= SIZE_W'(1021);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_MULT: mult_r <= cfg_pwdata[CFG_W-1:0];
        REG_MOD:  modu_r <= cfg_pwdata[CFG_W-1:0];
        REG_SIZE: size_r <= cfg_pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_MULT: cfg_prdata = {1'b0, mult_r};
      REG_MOD:  cfg_prdata = {1'b0, modu_r};
      REG_SIZE: cfg_prdata = {21'd0, size_r};
      default:  cfg_prdata = '0;
    endcase
  end

  // effective modulus and size
  word_t         modu_eff;
  logic [SW-1:0] size_eff;

  assign modu_eff = (modu_r == '0) ? CFG_W'(1) : modu_r;

  always_comb begin
    priority if (32'(size_r) < 32'd3)        size_eff = SW'(3);
    else if (32'(size_r) > 32'(DEPTH))       size_eff = SW'(DEPTH);
    else                                     size_eff = SW'(size_r);
  end

  // sequencer state
  logic [3:0]       state_r;
  logic [1:0]       phase_r;
  logic [1:0]       byte_r;
  logic [KIND_W-1:0] kind_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] wval_r;
  word_t            mulm_r;
  word_t            h_r;
  logic [61:0]      prod_r;
  logic [AW-1:0]    idx_r;
  logic [SW-1:0]    probe_r;
  logic [SW-1:0]    count_r;
  logic [EPOCH_BITS-1:0] epoch_r;
  logic [AW-1:0]    clr_r;
  logic             clr_item_r;

  logic             st_r;
  logic [DVD_W-1:0] dvd_r;
  word_t            dsr_r;
  logic             mod_done;
  word_t            mod_rem;

  logic [VAL_W-1:0] res_val_r;
  logic [AW-1:0]    res_slot_r;
  logic             res_new_r, res_full_r;

  logic [VAL_W-1:0] oval_r;
  logic [SLOT_W-1:0] oslot_r;
  logic             onew_r, ofull_r, ovalid_r;

  // memories
  logic [EPOCH_BITS-1:0] tag_mem [DEPTH];
  logic [KEY_W-1:0]      key_mem [DEPTH];
  logic [VAL_W-1:0]      val_mem [DEPTH];
  logic [EPOCH_BITS-1:0] tag_rd;
  logic [KEY_W-1:0]      key_rd;
  logic [VAL_W-1:0]      val_rd;

  logic                  tag_we, key_we, val_we;
  logic [AW-1:0]         tag_wa;
  logic [EPOCH_BITS-1:0] tag_wd;
  logic [VAL_W-1:0]      val_wd;

  logic tag_free, key_hit, full_now;
  logic [AW-1:0] idx_inc;

  assign tag_free = (tag_rd != epoch_r);
  assign key_hit  = (key_rd == key_r);
  assign full_now = (count_r + 1'b1) >= size_eff;
  assign idx_inc  = ((SW'(idx_r) + 1'b1) == size_eff) ? '0 : idx_r + 1'b1;

  // memory write controls
  always_comb begin
    tag_we = 1'b0;
    key_we = 1'b0;
    val_we = 1'b0;
    tag_wa = idx_r;
    tag_wd = epoch_r;
    val_wd = (kind_r == KIND_WRITE) ? wval_r : '0;
    if (state_r == S_CLR) begin
      tag_we = 1'b1;
      tag_wa = clr_r;
      tag_wd = '0;
    end else if (state_r == S_CHK) begin
      if (tag_free) begin
        tag_we = !full_now;
        key_we = !full_now;
        val_we = !full_now;
      end else if (key_hit) begin
        val_we = (kind_r == KIND_WRITE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_wa] <= tag_wd;
    tag_rd <= tag_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[idx_r] <= key_r;
    key_rd <= key_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[idx_r] <= val_wd;
    val_rd <= val_mem[idx_r];
  end

  // shared remainder unit
  htlp_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (st_r),
    .dividend  (dvd_r),
    .divisor   (dsr_r),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // main sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_r      <= '0;
      clr_item_r <= 1'b0;
      epoch_r    <= EPOCH_BITS'(1);
      count_r    <= '0;
      st_r       <= 1'b0;
      ovalid_r   <= 1'b0;
    end else begin
      st_r <= 1'b0;
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(DEPTH-1)) begin
            state_r <= clr_item_r ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            kind_r     <= in_tuser;
            key_r      <= in_tdata[KEY_W-1:0];
            wval_r     <= in_tdata[63:32];
            res_val_r  <= '0;
            res_slot_r <= '0;
            res_new_r  <= 1'b0;
            res_full_r <= 1'b0;
            if (in_tuser == KIND_CLEAR) begin
              count_r <= '0;
              if (epoch_r + 1'b1 == '0) begin
                epoch_r    <= EPOCH_BITS'(1);
                clr_r      <= '0;
                clr_item_r <= 1'b1;
                state_r    <= S_CLR;
              end else begin
                epoch_r <= epoch_r + 1'b1;
                state_r <= S_DONE;
              end
            end else if (in_tuser == KIND_READ || in_tuser == KIND_WRITE) begin
              st_r    <= 1'b1;
              dvd_r   <= DVD_W'(mult_r);
              dsr_r   <= modu_eff;
              phase_r <= P_MUL;
              state_r <= S_MODW;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_MODW: begin
          if (mod_done) begin
            unique case (phase_r)
              P_MUL: begin
                mulm_r  <= mod_rem;
                h_r     <= '0;
                byte_r  <= '0;
                state_r <= S_MULT;
              end
              P_BYTE: begin
                h_r <= mod_rem;
                if (byte_r == 2'd3) begin
                  st_r    <= 1'b1;
                  dvd_r   <= DVD_W'(mod_rem);
                  dsr_r   <= CFG_W'(size_eff);
                  phase_r <= P_SIZE;
                end else begin
                  byte_r  <= byte_r + 1'b1;
                  state_r <= S_MULT;
                end
              end
              default: begin
                idx_r   <= mod_rem[AW-1:0];
                probe_r <= '0;
                state_r <= S_RD;
              end
            endcase
          end
        end
        S_MULT: begin
          prod_r  <= h_r * mulm_r;
          state_r <= S_ADDB;
        end
        S_ADDB: begin
          st_r    <= 1'b1;
          dvd_r   <= DVD_W'(prod_r) + DVD_W'(key_r[byte_r*8 +: 8]);
          dsr_r   <= modu_eff;
          phase_r <= P_BYTE;
          state_r <= S_MODW;
        end
        S_RD: begin
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (tag_free) begin
            state_r <= S_DONE;
            if (full_now) begin
              res_full_r <= 1'b1;
            end else begin
              count_r    <= count_r + 1'b1;
              res_val_r  <= val_wd;
              res_slot_r <= idx_r;
              res_new_r  <= 1'b1;
            end
          end else if (key_hit) begin
            state_r    <= S_DONE;
            res_val_r  <= (kind_r == KIND_WRITE) ? wval_r : val_rd;
            res_slot_r <= idx_r;
          end else if (probe_r + 1'b1 >= size_eff) begin
            state_r    <= S_DONE;
            res_full_r <= 1'b1;
          end else begin
            probe_r <= probe_r + 1'b1;
            idx_r   <= idx_inc;
            state_r <= S_RD;
          end
        end
        S_DONE: begin
          if (!ovalid_r) begin
            oval_r     <= res_val_r;
            oslot_r    <= SLOT_W'(res_slot_r);
            onew_r     <= res_new_r;
            ofull_r    <= res_full_r;
            ovalid_r   <= 1'b1;
            clr_item_r <= 1'b0;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {4'd0, ofull_r, onew_r, oslot_r, oval_r};

  // checks
  a_count_below_size: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < size_eff || state_r == S_IDLE)
    else $error("entry count reached table size");

  a_chk_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHK |-> $past(state_r) == S_RD)
    else $error("slot check without read");

  a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    epoch_r != '0)
    else $error("epoch is zero");

endmodule

// ----- hdl/htlp_mod.sv -----
module htlp_mod (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [63:0]           dividend,
  input  htlp_pkg::word_t       divisor,
  output logic                  done,
  output htlp_pkg::word_t       remainder
);
  import htlp_pkg::*;

  logic [DVD_W-1:0] dvd_r;
  word_t            dsr_r;
  word_t            rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [CFG_W:0]   shifted;
  logic [CFG_W:0]   diff;

  // one remainder bit a cycle, restoring
  assign shifted = {rem_r, dvd_r[DVD_W-1]};
  assign diff    = shifted - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= dividend;
        dsr_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
        rem_r <= diff[CFG_W] ? shifted[CFG_W-1:0] : diff[CFG_W-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVD_W-1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule
